FILE: hdl/tofrf_pkg.sv
// ----------------------------------------------------------------------------
// tofrf_pkg
// Shared types, codes and tables for the ranging-sensor register file.
// ----------------------------------------------------------------------------
package tofrf_pkg;

  localparam int unsigned AddrW = 8;
  localparam int unsigned Depth = 1 << AddrW;

  localparam logic [2:0] OP_START_WRITE = 3'd0;
  localparam logic [2:0] OP_START_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE_BYTE  = 3'd2;
  localparam logic [2:0] OP_READ_BYTE   = 3'd3;
  localparam logic [2:0] OP_STOP        = 3'd4;
  localparam logic [2:0] OP_UNUSED      = 3'd7;

  localparam logic [12:0] MAX_RANGE_MM = 13'd8191;

  localparam logic [7:0] ADDR_RANGE_START  = 8'h00;
  localparam logic [7:0] ADDR_INT_CLEAR    = 8'h0B;
  localparam logic [7:0] ADDR_INT_STATUS   = 8'h13;
  localparam logic [7:0] ADDR_RANGE_STATUS = 8'h14;
  localparam logic [7:0] ADDR_RANGE_HI     = 8'h1E;
  localparam logic [7:0] ADDR_RANGE_LO     = 8'h1F;
  localparam logic [7:0] ADDR_FIXED_ONE    = 8'h83;
  localparam logic [7:0] ADDR_SPAD_SELECT  = 8'h94;
  localparam logic [5:0] ADDR_SPAD_BASE_HI = 6'b100100;  // 0x90..0x93

  localparam logic [7:0] SPAD_KEY     = 8'h6B;
  localparam logic [7:0] SPAD_MAP_2   = 8'h84;
  localparam logic [7:0] SPAD_FILL    = 8'hFF;
  localparam logic [7:0] STATUS_READY = 8'h04;
  localparam logic [7:0] RANGE_VALID  = 8'h01;
  localparam logic [7:0] FIXED_ONE    = 8'h01;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  write_data;
    logic [15:0] range_mm;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       ack;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_SIDE
  } state_t;

  typedef enum logic [1:0] {
    SIDE_NONE,
    SIDE_CLEAR,
    SIDE_RANGE,
    SIDE_SPAD
  } side_t;

  typedef struct packed {
    logic load_item;
    logic store;
    logic load_ptr;
    logic set_flag;
    logic fetch;
    logic side_wr;
    logic finish_rd;
    logic finish_zero;
  } cmd_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       expect_ptr;
    logic       side_hit;
    logic       side_last;
  } status_t;

  // Power-on contents of the bank, including the 250 mm startup measurement.
  function automatic logic [7:0] default_byte(input logic [7:0] addr);
    logic [7:0] v;
    case (addr)
      8'h13:   v = 8'h04;
      8'h14:   v = 8'h01;
      8'h1F:   v = 8'hFA;
      8'h50:   v = 8'h07;
      8'h70:   v = 8'h05;
      8'h84:   v = 8'h01;
      8'h91:   v = 8'h3C;
      8'hC0:   v = 8'hEE;
      8'hC1:   v = 8'hAA;
      8'hC2:   v = 8'h10;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/tof_sensor_i2c_register_file_top.sv
// ----------------------------------------------------------------------------
// tof_sensor_i2c_register_file_top
// Ranging-sensor register map behind a byte-level serial slave: 256-byte
// bank, auto-incrementing pointer, write side effects.
//
//   channel   ports                    handshake
//   item      start, busy, item        taken when start && !busy
//   result    done, result             one-cycle strobe, no back-pressure
//
// A beat goes through ST_EXEC alone for control opcodes, pointer loads and
// plain data bytes, ST_EXEC then ST_FETCH for a read byte (registered bank
// read), and ST_EXEC then ST_SIDE for a data byte with side effects, fed by
// the single bank write port (one side byte per cycle). The result appears
// the cycle after the last step; busy is already low. Reset (synchronous)
// clears control state and the bank's valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tof_sensor_i2c_register_file_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  tofrf_pkg::item_t    item,
  output logic                done,
  output tofrf_pkg::result_t  result
);

  tofrf_pkg::cmd_t    cmd;
  tofrf_pkg::status_t status;

  tofrf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  tofrf_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .result (result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

endmodule

FILE: hdl/tofrf_ctrl.sv
// ----------------------------------------------------------------------------
// tofrf_ctrl
// Sequencer: decodes each beat and steps the datapath through store,
// side-effect writes and fetch.
// ----------------------------------------------------------------------------
module tofrf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output tofrf_pkg::cmd_t    cmd,
  input  tofrf_pkg::status_t status
);

  tofrf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tofrf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      tofrf_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = tofrf_pkg::ST_EXEC;
        end
      end
      tofrf_pkg::ST_EXEC: begin
        case (status.opcode)
          tofrf_pkg::OP_WRITE_BYTE: begin
            if (status.expect_ptr) begin
              cmd.load_ptr    = 1'b1;
              cmd.finish_zero = 1'b1;
              state_next      = tofrf_pkg::ST_IDLE;
            end else begin
              cmd.store = 1'b1;
              if (status.side_hit) begin
                state_next = tofrf_pkg::ST_SIDE;
              end else begin
                cmd.finish_zero = 1'b1;
                state_next      = tofrf_pkg::ST_IDLE;
              end
            end
          end
          tofrf_pkg::OP_READ_BYTE: begin
            cmd.fetch  = 1'b1;
            state_next = tofrf_pkg::ST_FETCH;
          end
          tofrf_pkg::OP_START_WRITE, tofrf_pkg::OP_STOP: begin
            cmd.set_flag    = 1'b1;
            cmd.finish_zero = 1'b1;
            state_next      = tofrf_pkg::ST_IDLE;
          end
          default: begin
            cmd.finish_zero = 1'b1;
            state_next      = tofrf_pkg::ST_IDLE;
          end
        endcase
      end
      tofrf_pkg::ST_FETCH: begin
        cmd.finish_rd = 1'b1;
        state_next    = tofrf_pkg::ST_IDLE;
      end
      tofrf_pkg::ST_SIDE: begin
        cmd.side_wr = 1'b1;
        if (status.side_last) begin
          cmd.finish_zero = 1'b1;
          state_next      = tofrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tofrf_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != tofrf_pkg::ST_IDLE);

endmodule

FILE: hdl/tofrf_dp.sv
// ----------------------------------------------------------------------------
// tofrf_dp
// Datapath: register bank with per-entry valid bits, pointer, pointer-byte
// flag, side-effect write generator and result register.
// ----------------------------------------------------------------------------
module tofrf_dp (
  input  logic                clk,
  input  logic                rst,
  input  tofrf_pkg::item_t    item,
  input  tofrf_pkg::cmd_t     cmd,
  output tofrf_pkg::status_t  status,
  output logic                done,
  output tofrf_pkg::result_t  result
);

  logic [7:0]                 register_bank [tofrf_pkg::Depth];
  logic [tofrf_pkg::Depth-1:0] bank_valid;

  tofrf_pkg::item_t item_q;
  logic [7:0]       pointer;
  logic             expect_ptr;
  tofrf_pkg::side_t side_kind;
  tofrf_pkg::side_t side_kind_next;
  logic [1:0]       side_step;
  logic [7:0]       rd_q;
  logic             rd_valid;
  logic [7:0]       rd_addr;

  logic             we;
  logic [7:0]       waddr;
  logic [7:0]       wdata;
  logic [12:0]      range_sat;
  logic [7:0]       rd_sel;

  assign range_sat = (item_q.range_mm > {3'b000, tofrf_pkg::MAX_RANGE_MM})
                     ? tofrf_pkg::MAX_RANGE_MM : item_q.range_mm[12:0];

  always_comb begin
    case (pointer)
      tofrf_pkg::ADDR_INT_CLEAR:   side_kind_next = tofrf_pkg::SIDE_CLEAR;
      tofrf_pkg::ADDR_RANGE_START: side_kind_next = tofrf_pkg::SIDE_RANGE;
      tofrf_pkg::ADDR_SPAD_SELECT: side_kind_next = tofrf_pkg::SIDE_SPAD;
      default:                     side_kind_next = tofrf_pkg::SIDE_NONE;
    endcase
  end

  assign status.opcode     = item_q.opcode;
  assign status.expect_ptr = expect_ptr;
  assign status.side_hit   = (side_kind_next != tofrf_pkg::SIDE_NONE);
  assign status.side_last  = (side_kind == tofrf_pkg::SIDE_CLEAR) ? (side_step == 2'd1)
                                                                  : (side_step == 2'd3);

  // Write port: the data byte itself, then one side-effect byte a cycle.
  always_comb begin
    we    = 1'b0;
    waddr = pointer;
    wdata = item_q.write_data;
    if (cmd.store) begin
      we = 1'b1;
    end else if (cmd.side_wr) begin
      we = 1'b1;
      case (side_kind)
        tofrf_pkg::SIDE_CLEAR: begin
          waddr = side_step[0] ? tofrf_pkg::ADDR_RANGE_STATUS : tofrf_pkg::ADDR_INT_STATUS;
          wdata = 8'h00;
        end
        tofrf_pkg::SIDE_RANGE: begin
          case (side_step)
            2'd0: begin
              waddr = tofrf_pkg::ADDR_RANGE_HI;
              wdata = {3'b000, range_sat[12:8]};
            end
            2'd1: begin
              waddr = tofrf_pkg::ADDR_RANGE_LO;
              wdata = range_sat[7:0];
            end
            2'd2: begin
              waddr = tofrf_pkg::ADDR_INT_STATUS;
              wdata = tofrf_pkg::STATUS_READY;
            end
            default: begin
              waddr = tofrf_pkg::ADDR_RANGE_STATUS;
              wdata = tofrf_pkg::RANGE_VALID;
            end
          endcase
        end
        tofrf_pkg::SIDE_SPAD: begin
          waddr = {tofrf_pkg::ADDR_SPAD_BASE_HI, side_step};
          if (item_q.write_data == tofrf_pkg::SPAD_KEY) begin
            wdata = (side_step == 2'd2) ? tofrf_pkg::SPAD_MAP_2 : 8'h00;
          end else begin
            wdata = tofrf_pkg::SPAD_FILL;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      register_bank[waddr] <= wdata;
    end
    if (cmd.fetch) begin
      rd_q <= register_bank[pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= '0;
    end else if (we) begin
      bank_valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer    <= '0;
      expect_ptr <= 1'b0;
      side_kind  <= tofrf_pkg::SIDE_NONE;
      side_step  <= '0;
    end else begin
      if (cmd.set_flag) begin
        expect_ptr <= 1'b1;
      end
      if (cmd.load_ptr) begin
        pointer    <= item_q.write_data;
        expect_ptr <= 1'b0;
      end
      if (cmd.store || cmd.fetch) begin
        pointer <= pointer + 8'd1;
      end
      if (cmd.store) begin
        side_kind <= side_kind_next;
        side_step <= '0;
      end else if (cmd.side_wr) begin
        side_step <= side_step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_q <= item;
    end
    if (cmd.fetch) begin
      rd_valid <= bank_valid[pointer];
      rd_addr  <= pointer;
    end
  end

  always_comb begin
    if (rd_addr == tofrf_pkg::ADDR_RANGE_START) begin
      rd_sel = 8'h00;
    end else if (rd_addr == tofrf_pkg::ADDR_FIXED_ONE) begin
      rd_sel = tofrf_pkg::FIXED_ONE;
    end else if (rd_valid) begin
      rd_sel = rd_q;
    end else begin
      rd_sel = tofrf_pkg::default_byte(rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_rd || cmd.finish_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_rd) begin
      result.read_data <= rd_sel;
      result.ack       <= 1'b1;
    end else if (cmd.finish_zero) begin
      result.read_data <= 8'h00;
      result.ack       <= 1'b1;
    end
  end

  a_side_after_store: assert property (@(posedge clk) disable iff (rst)
    (cmd.store && status.side_hit) |=> (side_kind != tofrf_pkg::SIDE_NONE))
    else $error("side-effect sequence started with no kind");

  a_one_finish: assert property (@(posedge clk) disable iff (rst)
    !(cmd.finish_rd && cmd.finish_zero))
    else $error("two finish commands in one cycle");

  a_done_ack: assert property (@(posedge clk) disable iff (rst)
    done |-> result.ack)
    else $error("beat delivered without ack");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the ranging-sensor register file. A directed table walks
// reset values, pointer loads, every opcode, the write side effects
// (interrupt clear, range latch with saturation, SPAD select), the fixed
// read addresses and pointer wrap. Random bus transactions follow: mostly
// well-formed write and read bursts aimed at the special addresses, plus
// noise. Each result is checked against a shadow bank copy or a fixed table byte.
// ----------------------------------------------------------------------------
module tb;

  localparam int RAND_BEATS = 550;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    tofrf_pkg::item_t it;
    bit               fixed;
    logic [7:0]       rd;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  tofrf_pkg::item_t   item;
  logic               done;
  tofrf_pkg::result_t result;

  tof_sensor_i2c_register_file_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  logic [7:0]         reg_image [tofrf_pkg::Depth];
  logic [7:0]         ptr_shadow;
  bit                 ptr_pending;
  tofrf_pkg::result_t pending_results [$];
  plan_row_t          plan [$];
  int                 errors;
  int                 beats_sent;
  int                 idle_pct;
  int                 stall_cycles;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void latch_range(input logic [15:0] mm);
    logic [12:0] sat;
    sat = (mm > 16'(tofrf_pkg::MAX_RANGE_MM)) ? tofrf_pkg::MAX_RANGE_MM : mm[12:0];
    reg_image[tofrf_pkg::ADDR_RANGE_HI] = {3'b000, sat[12:8]};
    reg_image[tofrf_pkg::ADDR_RANGE_LO] = sat[7:0];
    reg_image[tofrf_pkg::ADDR_INT_STATUS] = tofrf_pkg::STATUS_READY;
    reg_image[tofrf_pkg::ADDR_RANGE_STATUS] = tofrf_pkg::RANGE_VALID;
  endfunction

  function automatic void power_on_image();
    for (int i = 0; i < tofrf_pkg::Depth; i++) reg_image[i] = 8'h00;
    reg_image[8'hC0] = 8'hEE;
    reg_image[8'hC1] = 8'hAA;
    reg_image[8'hC2] = 8'h10;
    reg_image[8'h50] = 8'h07;
    reg_image[8'h70] = 8'h05;
    reg_image[8'h84] = 8'h01;
    reg_image[8'h91] = 8'h3C;
    latch_range(16'd250);
    ptr_shadow = 8'h00;
    ptr_pending = 1'b0;
  endfunction

  function automatic tofrf_pkg::result_t bus_access(input tofrf_pkg::item_t it);
    tofrf_pkg::result_t r;
    logic [7:0]         a;
    r.read_data = 8'h00;
    r.ack = 1'b1;
    a = ptr_shadow;
    case (it.opcode)
      tofrf_pkg::OP_START_WRITE, tofrf_pkg::OP_STOP: ptr_pending = 1'b1;
      tofrf_pkg::OP_WRITE_BYTE: begin
        if (ptr_pending) begin
          ptr_shadow = it.write_data;
          ptr_pending = 1'b0;
        end else begin
          reg_image[a] = it.write_data;
          if (a == tofrf_pkg::ADDR_INT_CLEAR) begin
            reg_image[tofrf_pkg::ADDR_INT_STATUS] = 8'h00;
            reg_image[tofrf_pkg::ADDR_RANGE_STATUS] = 8'h00;
          end else if (a == tofrf_pkg::ADDR_RANGE_START) begin
            latch_range(it.range_mm);
          end else if (a == tofrf_pkg::ADDR_SPAD_SELECT) begin
            if (it.write_data == tofrf_pkg::SPAD_KEY) begin
              reg_image[8'h90] = 8'h00;
              reg_image[8'h91] = 8'h00;
              reg_image[8'h92] = tofrf_pkg::SPAD_MAP_2;
              reg_image[8'h93] = 8'h00;
            end else begin
              for (int i = 8'h90; i <= 8'h93; i++) reg_image[i] = tofrf_pkg::SPAD_FILL;
            end
          end
          ptr_shadow = a + 8'd1;
        end
      end
      tofrf_pkg::OP_READ_BYTE: begin
        if (a == tofrf_pkg::ADDR_RANGE_START) r.read_data = 8'h00;
        else if (a == tofrf_pkg::ADDR_FIXED_ONE) r.read_data = tofrf_pkg::FIXED_ONE;
        else r.read_data = reg_image[a];
        ptr_shadow = a + 8'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tofrf_pkg::item_t mk(input logic [2:0] op, input logic [7:0] wd,
                                          input logic [15:0] mm);
    tofrf_pkg::item_t it;
    it.opcode = op;
    it.write_data = wd;
    it.range_mm = mm;
    return it;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [7:0] wd,
                                  input logic [15:0] mm, input bit fixed,
                                  input logic [7:0] rd);
    plan_row_t row;
    row.it = mk(op, wd, mm);
    row.fixed = fixed;
    row.rd = rd;
    plan.push_back(row);
  endfunction

  function automatic logic [7:0] pick_addr();
    logic [7:0] hot [12] = '{8'h00, 8'h0B, 8'h13, 8'h14, 8'h1E, 8'h1F,
                             8'h83, 8'h90, 8'h92, 8'h94, 8'hFE, 8'hFF};
    if ($urandom_range(2) == 0) return 8'($urandom);
    return hot[$urandom_range(11)];
  endfunction

  function automatic logic [15:0] pick_mm();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'd8191;
      2: return 16'd8192;
      3: return 16'hFFFF;
      4: return 16'($urandom_range(8191));
      default: return 16'($urandom);
    endcase
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(input tofrf_pkg::item_t it, input bit fixed,
                           input logic [7:0] rd);
    tofrf_pkg::result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = bus_access(it);
    if (fixed) r.read_data = rd;
    pending_results.push_back(r);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    tofrf_pkg::result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected beat read_data=%h", result.read_data));
      end else begin
        want = pending_results.pop_front();
        if (result.read_data !== want.read_data)
          report($sformatf("read_data %h, want %h", result.read_data, want.read_data));
        if (result.ack !== want.ack)
          report($sformatf("ack %b, want %b", result.ack, want.ack));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tof_sensor_i2c_register_file_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int phase_idle [4] = '{0, 56, 0, 12};
    int kind;
    int len;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    errors = 0;
    beats_sent = 0;
    idle_pct = 0;
    power_on_image();

    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'hA5, 16'h0000, 0, 8'h00);  // no start: data
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h13, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h04);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h01);
    add_row(tofrf_pkg::OP_STOP,        8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h0B, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h55, 16'h0000, 1, 8'h00);  // interrupt clear
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h13, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'hFF, 16'hFFFF, 1, 8'h00);  // range latch, saturated
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h1E, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h1F);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'hFF);
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h94, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h6B, 16'h0000, 1, 8'h00);  // SPAD key
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h92, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h84);
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h83, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h01);
    add_row(tofrf_pkg::OP_UNUSED,      8'hFF, 16'hFFFF, 1, 8'h00);  // unused opcode
    add_row(tofrf_pkg::OP_START_READ,  8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_START_WRITE, 8'h00, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'hFF, 16'h0000, 1, 8'h00);
    add_row(tofrf_pkg::OP_WRITE_BYTE,  8'h5A, 16'h0000, 1, 8'h00);  // pointer wraps
    add_row(tofrf_pkg::OP_READ_BYTE,   8'h00, 16'h0000, 1, 8'h00);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_beat(plan[i].it, plan[i].fixed, plan[i].rd);
    drain();
    beats_sent = 0;

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      while (beats_sent < (phase + 1) * RAND_BEATS / 4) begin
        kind = $urandom_range(9);
        len = $urandom_range(1, 6);
        if (kind < 4) begin
          send_beat(mk(tofrf_pkg::OP_START_WRITE, 8'($urandom), pick_mm()), 0, 8'h00);
          send_beat(mk(tofrf_pkg::OP_WRITE_BYTE, pick_addr(), pick_mm()), 0, 8'h00);
          repeat (len)
            send_beat(mk(tofrf_pkg::OP_WRITE_BYTE,
                         ($urandom_range(3) == 0) ? tofrf_pkg::SPAD_KEY : 8'($urandom),
                         pick_mm()), 0, 8'h00);
          if ($urandom_range(3) != 0)
            send_beat(mk(tofrf_pkg::OP_STOP, 8'($urandom), pick_mm()), 0, 8'h00);
        end else if (kind < 8) begin
          send_beat(mk(tofrf_pkg::OP_START_WRITE, 8'($urandom), pick_mm()), 0, 8'h00);
          send_beat(mk(tofrf_pkg::OP_WRITE_BYTE, pick_addr(), pick_mm()), 0, 8'h00);
          if ($urandom_range(3) != 0)
            send_beat(mk(tofrf_pkg::OP_START_READ, 8'($urandom), pick_mm()), 0, 8'h00);
          repeat (len)
            send_beat(mk(tofrf_pkg::OP_READ_BYTE, 8'($urandom), pick_mm()), 0, 8'h00);
          send_beat(mk(tofrf_pkg::OP_STOP, 8'($urandom), pick_mm()), 0, 8'h00);
        end else begin
          repeat (len)
            send_beat(mk(3'($urandom), 8'($urandom), 16'($urandom)), 0, 8'h00);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (pending_results.size() != 0)
      report($sformatf("%0d beats never came", pending_results.size()));
    if (errors == 0) begin
      $display("tof_sensor_i2c_register_file_top regression: pass");
    end else begin
      $display("tof_sensor_i2c_register_file_top regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tofrf_pkg.sv
hdl/tofrf_ctrl.sv
hdl/tofrf_dp.sv
hdl/tof_sensor_i2c_register_file_top.sv
test/tb.sv
